FILE: hw/rtl/insertion_sort_engine_assert.svh
// Assertion macros used by the sort engine top module.
`ifndef INSERTION_SORT_ENGINE_ASSERT_SVH
`define INSERTION_SORT_ENGINE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ISE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ISE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/ise_pkg.sv
package ise_pkg;

    localparam int unsigned DATA_W = 32;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_in;    // capture value and last, pos = count
        logic set_drop;   // store full, flag overflow
        logic read_prev;  // read entry pos-1
        logic shift;      // write read entry at pos, pos--
        logic read_next;  // read entry pos-2 (after a shift)
        logic place;      // write value at pos, count++
        logic rd_issue;   // read entry k for readout
        logic rd_load;    // load output register, k++
        logic clear;      // end of run: count, dropped, k to zero
    } ise_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic full;
        logic cnt_zero;
        logic gt;         // read entry strictly greater than value
        logic pos_one;
        logic rd_last;    // entry k is the final one of the run
        logic last;
        logic out_free;
    } ise_sts_t;

endpackage

FILE: hw/rtl/insertion_sort_engine.sv
// Insertion sort engine for runs of signed 32-bit values.
// Input channel (in_valid/in_ready, value, last): one request per value; the
// request with last set closes the run. Output channel (out_valid/out_ready,
// sorted_value, last_res, overflow): the run in ascending order, last_res on
// the final value, overflow on every value of a run that lost values because
// the store of DEPTH entries was full. Equal values leave in arrival order.
// Insertion moves the stored entries greater than the value (at most DEPTH-1)
// up by one place, one entry per cycle, since the store is single-port; a
// value that finds the store empty or full is placed or dropped with no shift.
// in_ready is high only while no value is being inserted or read out.
// Readout reads each result from the store, then loads it into the output
// register.
// A stalled receiver holds the output register and pauses the readout; the
// next run's first request is accepted while the final result still waits.
// Reset clears the entry count and the overflow flag; store contents stay
// undefined and are never read before written, so no clearing pass runs.
module insertion_sort_engine #(
    parameter int unsigned DEPTH = 64
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic signed [ise_pkg::DATA_W-1:0]  value,
    input  logic                               last,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [ise_pkg::DATA_W-1:0]  sorted_value,
    output logic                               last_res,
    output logic                               overflow
);

    ise_pkg::ise_cmd_t cmd;
    ise_pkg::ise_sts_t sts;

    ise_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ise_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .value        (value),
        .last         (last),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .sorted_value (sorted_value),
        .last_res     (last_res),
        .overflow     (overflow)
    );

`include "insertion_sort_engine_assert.svh"

    `ISE_ASSERT_NOW(a_no_write_when_full, cmd.place, !sts.full, "store written past depth")
    `ISE_ASSERT_NOW(a_final_clears, cmd.rd_load && sts.rd_last, cmd.clear,
        "final readout did not clear the run")
    `ISE_ASSERT_NOW(a_shift_needs_greater, cmd.shift, sts.gt && !cmd.place,
        "shift without a greater entry")
    `ISE_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready,
        "request accepted while previous insertion pending")

endmodule

FILE: hw/rtl/ise_ctrl.sv
module ise_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  ise_pkg::ise_sts_t sts,
    output ise_pkg::ise_cmd_t cmd
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_CHECK    = 3'd1;
    localparam logic [2:0] S_SHIFT    = 3'd2;
    localparam logic [2:0] S_PLACE    = 3'd3;
    localparam logic [2:0] S_RD_ISSUE = 3'd4;
    localparam logic [2:0] S_RD_LOAD  = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic [2:0] after_insert;

    assign in_ready     = (state_reg == S_IDLE);
    assign after_insert = sts.last ? S_RD_ISSUE : S_IDLE;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (sts.full)
                begin
                    cmd.set_drop = 1'b1;
                    state_next   = after_insert;
                end
                else if (sts.cnt_zero)
                begin
                    cmd.place  = 1'b1;
                    state_next = after_insert;
                end
                else
                begin
                    cmd.read_prev = 1'b1;
                    state_next    = S_SHIFT;
                end
            end
            S_SHIFT:
            begin
                if (sts.gt)
                begin
                    cmd.shift = 1'b1;
                    if (sts.pos_one)
                    begin
                        state_next = S_PLACE;
                    end
                    else
                    begin
                        cmd.read_next = 1'b1;
                    end
                end
                else
                begin
                    cmd.place  = 1'b1;
                    state_next = after_insert;
                end
            end
            S_PLACE:
            begin
                cmd.place  = 1'b1;
                state_next = after_insert;
            end
            S_RD_ISSUE:
            begin
                // hold the read until the output register can take it
                if (sts.out_free)
                begin
                    cmd.rd_issue = 1'b1;
                    state_next   = S_RD_LOAD;
                end
            end
            S_RD_LOAD:
            begin
                cmd.rd_load = 1'b1;
                if (sts.rd_last)
                begin
                    cmd.clear  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_RD_ISSUE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: hw/rtl/ise_dp.sv
module ise_dp #(
    parameter int unsigned DEPTH = 64
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  ise_pkg::ise_cmd_t                  cmd,
    output ise_pkg::ise_sts_t                  sts,
    input  logic signed [ise_pkg::DATA_W-1:0]  value,
    input  logic                               last,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [ise_pkg::DATA_W-1:0]  sorted_value,
    output logic                               last_res,
    output logic                               overflow
);

    localparam int unsigned IW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);

    logic [ise_pkg::DATA_W-1:0]        mem [DEPTH];
    logic signed [ise_pkg::DATA_W-1:0] rdata_reg;
    logic signed [ise_pkg::DATA_W-1:0] value_reg;
    logic                              last_reg;
    logic [CW-1:0]                     pos_reg;
    logic [CW-1:0]                     count_reg;
    logic                              dropped_reg;
    logic [IW-1:0]                     k_reg;
    logic                              out_valid_reg;
    logic signed [ise_pkg::DATA_W-1:0] out_value_reg;
    logic                              out_last_reg;
    logic                              out_ovf_reg;

    logic                              mem_we;
    logic [ise_pkg::DATA_W-1:0]        mem_wdata;
    logic                              mem_re;
    logic [IW-1:0]                     mem_raddr;
    logic [CW-1:0]                     pos_m1;
    logic [CW-1:0]                     pos_m2;

    assign pos_m1    = pos_reg - CW'(1);
    assign pos_m2    = pos_reg - CW'(2);
    assign mem_we    = cmd.shift | cmd.place;
    assign mem_wdata = cmd.shift ? rdata_reg : value_reg;
    assign mem_re    = cmd.read_prev | cmd.read_next | cmd.rd_issue;

    always_comb
    begin
        if (cmd.rd_issue)
        begin
            mem_raddr = k_reg;
        end
        else if (cmd.read_next)
        begin
            mem_raddr = pos_m2[IW-1:0];
        end
        else
        begin
            mem_raddr = pos_m1[IW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[pos_reg[IW-1:0]] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            value_reg <= value;
            last_reg  <= last;
        end
        if (cmd.rd_load)
        begin
            out_value_reg <= rdata_reg;
            out_last_reg  <= sts.rd_last;
            out_ovf_reg   <= dropped_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            count_reg     <= '0;
            dropped_reg   <= 1'b0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load_in)
            begin
                pos_reg <= count_reg;
            end
            else if (cmd.shift)
            begin
                pos_reg <= pos_m1;
            end
            if (cmd.clear)
            begin
                count_reg   <= '0;
                dropped_reg <= 1'b0;
                k_reg       <= '0;
            end
            else
            begin
                if (cmd.place)
                begin
                    count_reg <= count_reg + CW'(1);
                end
                if (cmd.set_drop)
                begin
                    dropped_reg <= 1'b1;
                end
                if (cmd.rd_load)
                begin
                    k_reg <= k_reg + IW'(1);
                end
            end
            if (cmd.rd_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign sts.full     = (count_reg == CW'(DEPTH));
    assign sts.cnt_zero = (count_reg == '0);
    assign sts.gt       = (rdata_reg > value_reg);
    assign sts.pos_one  = (pos_reg == CW'(1));
    assign sts.rd_last  = ((CW'(k_reg) + CW'(1)) == count_reg);
    assign sts.last     = last_reg;
    assign sts.out_free = !out_valid_reg || out_ready;

    assign out_valid    = out_valid_reg;
    assign sorted_value = out_value_reg;
    assign last_res     = out_last_reg;
    assign overflow     = out_ovf_reg;

endmodule

FILE: tb/tb_insertion_sort_engine.sv
module tb_insertion_sort_engine;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned DEPTH       = 64;
    localparam int          STALL_LIMIT = 4000;
    localparam int          TAIL_CYCLES = 2 * DEPTH + 16;
    localparam int          RANDOM_REQS = 306;

    typedef logic signed [ise_pkg::DATA_W-1:0] word_t;

    typedef struct packed {
        word_t val;
        logic  fin;
        logic  ovf;
    } sorted_t;

    typedef struct packed {
        word_t   val;
        logic    fin;
        logic    typed;
        sorted_t res;
    } req_row_t;

    localparam word_t MIN_W = 32'sh8000_0000;
    localparam word_t MAX_W = 32'sh7FFF_FFFF;

    // Single-value runs carry their result typed in; the rest go through the predictor.
    localparam req_row_t DIRECTED [24] = '{
        '{MIN_W,          1'b1, 1'b1, '{MIN_W, 1'b1, 1'b0}},
        '{MAX_W,          1'b1, 1'b1, '{MAX_W, 1'b1, 1'b0}},
        '{32'sd0,         1'b1, 1'b1, '{32'sd0, 1'b1, 1'b0}},
        '{-32'sd1,        1'b1, 1'b1, '{-32'sd1, 1'b1, 1'b0}},
        '{32'sd100,       1'b0, 1'b0, '0},
        '{32'sd50,        1'b0, 1'b0, '0},
        '{32'sd0,         1'b0, 1'b0, '0},
        '{-32'sd50,       1'b0, 1'b0, '0},
        '{-32'sd100,      1'b1, 1'b0, '0},
        '{32'sd7,         1'b0, 1'b0, '0},
        '{32'sd7,         1'b0, 1'b0, '0},
        '{-32'sd3,        1'b0, 1'b0, '0},
        '{32'sd7,         1'b0, 1'b0, '0},
        '{-32'sd3,        1'b1, 1'b0, '0},
        '{MIN_W,          1'b0, 1'b0, '0},
        '{-32'sd1,        1'b0, 1'b0, '0},
        '{32'sd0,         1'b0, 1'b0, '0},
        '{MAX_W,          1'b1, 1'b0, '0},
        '{32'sh5555_5555, 1'b0, 1'b0, '0},
        '{32'shAAAA_AAAA, 1'b0, 1'b0, '0},
        '{32'sh0000_0001, 1'b0, 1'b0, '0},
        '{32'shFFFF_FFFE, 1'b1, 1'b0, '0},
        '{MAX_W,          1'b0, 1'b0, '0},
        '{MIN_W,          1'b1, 1'b0, '0}
    };

    logic  clk;
    logic  rst_n;
    logic  in_valid;
    logic  in_ready;
    word_t value;
    logic  last;
    logic  out_valid;
    logic  out_ready;
    word_t sorted_value;
    logic  last_res;
    logic  overflow;

    // Sort predictor state
    word_t       store_mem [DEPTH];
    int          fill;
    logic        lost;
    sorted_t     run_out [DEPTH];
    sorted_t     sorted_q [$];

    int          errors;
    int          quiet_cycles;
    logic        calm;

    insertion_sort_engine #(
        .DEPTH (DEPTH)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .value        (value),
        .last         (last),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .sorted_value (sorted_value),
        .last_res     (last_res),
        .overflow     (overflow)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic void note_error(input string msg);
        errors++;
        if (errors <= 10)
            $display("%s", msg);
    endfunction

    // Insert one value; on the closing request, fill run_out and clear for the next run.
    function automatic int sort_step(input word_t v, input logic fin);
        int pos;
        int n;
        if (fill >= DEPTH)
            lost = 1'b1;
        else
        begin
            pos = fill;
            while (pos > 0 && store_mem[pos-1] > v)
            begin
                store_mem[pos] = store_mem[pos-1];
                pos--;
            end
            store_mem[pos] = v;
            fill++;
        end
        if (!fin)
            return 0;
        n = fill;
        for (int k = 0; k < n; k++)
            run_out[k] = '{store_mem[k], (k == n - 1), lost};
        fill = 0;
        lost = 1'b0;
        return n;
    endfunction

    function automatic word_t pick_value();
        case ($urandom_range(19))
            0:             return MIN_W;
            1:             return MAX_W;
            2, 3, 4, 5, 6: return word_t'($urandom_range(8)) - 32'sd4;
            default:       return word_t'($urandom);
        endcase
    endfunction

    task automatic push_request(input word_t v, input logic fin, input logic typed,
                                input sorted_t typed_res);
        int n;
        while (!calm && $urandom_range(99) < 14)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        value    = v;
        last     = fin;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        n = sort_step(v, fin);
        if (typed)
            sorted_q.push_back(typed_res);
        else
            for (int k = 0; k < n; k++)
                sorted_q.push_back(run_out[k]);
        @(negedge clk);
    endtask

    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            out_ready = calm || ($urandom_range(99) >= 14);
        end
    end

    always @(posedge clk)
    begin
        sorted_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (sorted_q.size() == 0)
                note_error($sformatf("unexpected result: sorted_value=%0d last_res=%0b overflow=%0b",
                                     sorted_value, last_res, overflow));
            else
            begin
                want = sorted_q.pop_front();
                if (sorted_value !== want.val || last_res !== want.fin ||
                    overflow !== want.ovf)
                    note_error($sformatf("mismatch: expected %0d/%0b/%0b, got %0d/%0b/%0b",
                                         want.val, want.fin, want.ovf,
                                         sorted_value, last_res, overflow));
            end
        end
    end

    // End the run when neither channel moves for too long.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles = 0;
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
        end
    end

    initial
    begin
        int sent;
        int len;
        int run_idx;
        in_valid     = 1'b0;
        value        = '0;
        last         = 1'b0;
        rst_n        = 1'b0;
        calm         = 1'b0;
        fill         = 0;
        lost         = 1'b0;
        errors       = 0;
        quiet_cycles = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (DIRECTED[i])
            push_request(DIRECTED[i].val, DIRECTED[i].fin, DIRECTED[i].typed, DIRECTED[i].res);

        // Mostly short runs; three long ones exactly fill, then overflow, the store.
        sent    = 0;
        run_idx = 0;
        while (sent < RANDOM_REQS)
        begin
            case (run_idx)
                2:       len = DEPTH;
                9:       len = DEPTH + 1;
                16:      len = DEPTH + 6;
                default: len = $urandom_range(10, 1);
            endcase
            calm = (run_idx >= 8 && run_idx <= 10);
            for (int i = 0; i < len; i++)
                push_request(pick_value(), (i == len - 1), 1'b0, '0);
            sent += len;
            run_idx++;
        end
        calm     = 1'b0;
        in_valid = 1'b0;

        while (sorted_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
